/* design/gdn_pkg.sv */
// Package: field widths, calendar constants and day count helpers.
package gdn_pkg;

    localparam int YEAR_W   = 13;
    localparam int FYEAR_W  = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int DNUM_W   = 19;
    localparam int WDAY_W   = 3;
    localparam int ABS_W    = 22;
    localparam int YWIDE_W  = 14;
    localparam int DOY_W    = 9;

    localparam logic [FYEAR_W-1:0] FIRST_YEAR_RESET = 12'd1601;
    localparam logic [ABS_W-1:0]   DNUM_MAX         = 22'd524287;
    localparam logic [12:0]        DIV100_MUL       = 13'd5243;
    localparam logic [21:0]        YEAR_RECIP       = 22'd2939805;
    localparam int                 YEAR_RECIP_SH    = 30;
    localparam logic [MONTH_W-1:0] MONTH_JAN        = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB        = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC        = 4'd12;
    localparam logic               OP_TO_DNUM       = 1'b0;
    localparam logic               OP_TO_DATE       = 1'b1;

    function automatic logic [7:0] div100(input logic [13:0] x);
        logic [26:0] p;
        p = 27'(x) * 27'(DIV100_MUL);
        return p[26:19];
    endfunction

    function automatic logic [ABS_W-1:0] abs_days(input logic [YWIDE_W-1:0] y);
        logic [14:0] y3;
        logic [14:0] y99;
        logic [14:0] y399;
        logic [7:0]  c100;
        logic [7:0]  c400;
        y3   = 15'(y) + 15'd3;
        y99  = 15'(y) + 15'd99;
        y399 = 15'(y) + 15'd399;
        c100 = div100(y99[13:0]);
        c400 = div100(14'(y399[14:2]));
        return 22'(y) * 22'd365 + 22'(y3[14:2]) - 22'(c100) + 22'(c400);
    endfunction

    function automatic logic is_leap(input logic [YWIDE_W-1:0] y);
        logic [7:0]  q;
        logic [13:0] r;
        q = div100(y);
        r = y - ((14'(q) << 6) + (14'(q) << 5) + (14'(q) << 2));
        return ((r != 14'd0) && (y[1:0] == 2'b00)) || ((r == 14'd0) && (q[1:0] == 2'b00));
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [DOY_W-1:0] cum_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
        logic [DOY_W-1:0] c;
        logic [DOY_W-1:0] l;
        l = leap ? 9'd1 : 9'd0;
        unique case (m)
            4'd1:    c = 9'd0;
            4'd2:    c = 9'd31;
            4'd3:    c = 9'd59 + l;
            4'd4:    c = 9'd90 + l;
            4'd5:    c = 9'd120 + l;
            4'd6:    c = 9'd151 + l;
            4'd7:    c = 9'd181 + l;
            4'd8:    c = 9'd212 + l;
            4'd9:    c = 9'd243 + l;
            4'd10:   c = 9'd273 + l;
            4'd11:   c = 9'd304 + l;
            4'd12:   c = 9'd334 + l;
            default: c = 9'd0;
        endcase
        return c;
    endfunction

endpackage

/* design/gdn_req_if.sv */
// Interface: conversion request channel.
interface gdn_req_if;
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [gdn_pkg::YEAR_W-1:0]    year;
    logic [gdn_pkg::MONTH_W-1:0]   month;
    logic [gdn_pkg::DAY_W-1:0]     day;
    logic [gdn_pkg::DNUM_W-1:0]    day_number;

    modport source (output valid, operation, year, month, day, day_number, input ready);
    modport sink   (input valid, operation, year, month, day, day_number, output ready);
endinterface

/* design/gdn_rsp_if.sv */
// Interface: conversion result channel.
interface gdn_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [gdn_pkg::DNUM_W-1:0]    out_day_number;
    logic [gdn_pkg::YEAR_W-1:0]    out_year;
    logic [gdn_pkg::MONTH_W-1:0]   out_month;
    logic [gdn_pkg::DAY_W-1:0]     out_day;
    logic [gdn_pkg::WDAY_W-1:0]    weekday;
    logic                          error;

    modport source (output valid, out_day_number, out_year, out_month, out_day, weekday,
                    error, input ready);
    modport sink   (input valid, out_day_number, out_year, out_month, out_day, weekday,
                    error, output ready);
endinterface

/* design/gdn_cfg_if.sv */
// Interface: first year register write channel.
interface gdn_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [gdn_pkg::FYEAR_W-1:0]   data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* design/gdn_weekday.sv */
// Weekday of a day number: mod 7 by octal digit folding, zero shown as seven.
module gdn_weekday (
    input  logic [gdn_pkg::DNUM_W-1:0] n,
    output logic [gdn_pkg::WDAY_W-1:0] wd
);
    logic [5:0] s1;
    logic [3:0] s2;
    logic [3:0] s3;
    logic [2:0] r;

    always_comb
    begin
        s1 = 6'(n[2:0]) + 6'(n[5:3]) + 6'(n[8:6]) + 6'(n[11:9]) + 6'(n[14:12])
           + 6'(n[17:15]) + 6'(n[18]);
        s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
        s3 = 4'(s2[2:0]) + 4'(s2[3]);
        r  = (s3 >= 4'd7) ? 3'(s3 - 4'd7) : s3[2:0];
        wd = (r == 3'd0) ? 3'd7 : r;
    end
endmodule

/* design/gregorian_day_number_converter.sv */
// Top level: pipelined Gregorian date and day number converter.
//
//  channel | dir | handshake    | carries
//  req     | in  | valid/ready  | operation, year, month, day, day_number
//  rsp     | out | valid/ready  | out_day_number, out_year, out_month, out_day, weekday, error
//  cfg     | in  | valid/ready  | data (first_year)
//
// Six register stages; one request enters per cycle unless the pipe holds, and its result leaves from stage 6.
// Stage 3 holds the year estimate multiply, stage 4 the candidate year day counts.
// rst_n clears the valid bits and sets first_year to 1601.
// The whole pipe holds while a result waits on rsp; cfg is always ready.
module gregorian_day_number_converter #(
    parameter int YEAR_SPAN = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    gdn_req_if.sink    req,
    gdn_rsp_if.source  rsp,
    gdn_cfg_if.sink    cfg
);
    localparam logic [gdn_pkg::YEAR_W-1:0] SPAN = gdn_pkg::YEAR_W'(YEAR_SPAN);

    logic [gdn_pkg::FYEAR_W-1:0] first_year_reg;
    logic en;

    // stage 1
    logic v1_reg, op1_reg, leap1_reg, rok1_reg;
    logic [gdn_pkg::YEAR_W-1:0]  y1_reg;
    logic [gdn_pkg::MONTH_W-1:0] m1_reg;
    logic [gdn_pkg::DAY_W-1:0]   d1_reg;
    logic [gdn_pkg::DNUM_W-1:0]  n1_reg;
    logic [gdn_pkg::ABS_W-1:0]   fin1_reg, ffy1_reg, fend1_reg;
    // stage 2
    logic v2_reg, op2_reg, err2_reg;
    logic [gdn_pkg::YEAR_W-1:0]  y2_reg;
    logic [gdn_pkg::MONTH_W-1:0] m2_reg;
    logic [gdn_pkg::DAY_W-1:0]   d2_reg;
    logic [gdn_pkg::DNUM_W-1:0]  n2_reg;
    logic [gdn_pkg::ABS_W-1:0]   a2_reg;
    logic [gdn_pkg::ABS_W-1:0]   sum_next;
    logic                        err2_next;
    logic [gdn_pkg::DNUM_W-1:0]  n2_next;
    // stage 3
    logic v3_reg, op3_reg, err3_reg;
    logic [gdn_pkg::YEAR_W-1:0]  y3_reg;
    logic [gdn_pkg::MONTH_W-1:0] m3_reg;
    logic [gdn_pkg::DAY_W-1:0]   d3_reg;
    logic [gdn_pkg::DNUM_W-1:0]  n3_reg;
    logic [gdn_pkg::ABS_W-1:0]   a3_reg;
    logic [gdn_pkg::WDAY_W-1:0]  wd3_reg, wd_next;
    logic [gdn_pkg::YWIDE_W-1:0] est3_reg;
    logic [43:0]                 est_prod;
    // stage 4
    logic v4_reg, op4_reg, err4_reg;
    logic [gdn_pkg::YEAR_W-1:0]  y4_reg;
    logic [gdn_pkg::MONTH_W-1:0] m4_reg;
    logic [gdn_pkg::DAY_W-1:0]   d4_reg;
    logic [gdn_pkg::DNUM_W-1:0]  n4_reg;
    logic [gdn_pkg::ABS_W-1:0]   a4_reg, f4_reg;
    logic [gdn_pkg::WDAY_W-1:0]  wd4_reg;
    logic [gdn_pkg::YWIDE_W-1:0] yc4_reg;
    logic [gdn_pkg::YWIDE_W-1:0] base, yc_next;
    logic [gdn_pkg::ABS_W-1:0]   fb0, fb1, fb2, f_next;
    // stage 5
    logic v5_reg, op5_reg, err5_reg, leap5_reg;
    logic [gdn_pkg::YEAR_W-1:0]  y5_reg;
    logic [gdn_pkg::MONTH_W-1:0] m5_reg;
    logic [gdn_pkg::DAY_W-1:0]   d5_reg;
    logic [gdn_pkg::DNUM_W-1:0]  n5_reg;
    logic [gdn_pkg::WDAY_W-1:0]  wd5_reg;
    logic [gdn_pkg::YWIDE_W-1:0] yc5_reg;
    logic [gdn_pkg::DOY_W-1:0]   doy5_reg;
    logic [gdn_pkg::ABS_W-1:0]   doy_wide;
    // stage 6
    logic v6_reg, err6_reg;
    logic [gdn_pkg::DNUM_W-1:0]  on6_reg;
    logic [gdn_pkg::YEAR_W-1:0]  oy6_reg;
    logic [gdn_pkg::MONTH_W-1:0] om6_reg;
    logic [gdn_pkg::DAY_W-1:0]   od6_reg;
    logic [gdn_pkg::WDAY_W-1:0]  owd6_reg;
    logic [gdn_pkg::MONTH_W-1:0] msel;
    logic [gdn_pkg::DOY_W-1:0]   dsel;

    logic [gdn_pkg::YEAR_W-1:0]  end_year;

    assign en        = !v6_reg || rsp.ready;
    assign req.ready = en;
    assign cfg.ready = 1'b1;
    assign end_year  = gdn_pkg::YEAR_W'(first_year_reg) + SPAN;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_year_reg <= gdn_pkg::FIRST_YEAR_RESET;
        end
        else if (cfg.valid)
        begin
            first_year_reg <= cfg.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= req.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // stage 1: absolute day counts, leap flag and year range flag
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op1_reg   <= req.operation;
            y1_reg    <= req.year;
            m1_reg    <= req.month;
            d1_reg    <= req.day;
            n1_reg    <= req.day_number;
            leap1_reg <= gdn_pkg::is_leap(gdn_pkg::YWIDE_W'(req.year));
            rok1_reg  <= (req.year >= gdn_pkg::YEAR_W'(first_year_reg)) &&
                         (req.year < end_year);
            fin1_reg  <= gdn_pkg::abs_days(gdn_pkg::YWIDE_W'(req.year));
            ffy1_reg  <= gdn_pkg::abs_days(gdn_pkg::YWIDE_W'(first_year_reg));
            fend1_reg <= gdn_pkg::abs_days(gdn_pkg::YWIDE_W'(end_year));
        end
    end

    // stage 2: day number of a date, range check of a day number
    always_comb
    begin
        sum_next = fin1_reg - ffy1_reg
                 + gdn_pkg::ABS_W'(gdn_pkg::cum_days(m1_reg, leap1_reg))
                 + gdn_pkg::ABS_W'(d1_reg);
        if (op1_reg == gdn_pkg::OP_TO_DNUM)
        begin
            err2_next = !rok1_reg || (m1_reg < gdn_pkg::MONTH_JAN) ||
                        (m1_reg > gdn_pkg::MONTH_DEC) || (d1_reg == '0) ||
                        (d1_reg > gdn_pkg::month_len(m1_reg, leap1_reg)) ||
                        (sum_next > gdn_pkg::DNUM_MAX);
            n2_next   = sum_next[gdn_pkg::DNUM_W-1:0];
        end
        else
        begin
            err2_next = (n1_reg == '0) ||
                        (gdn_pkg::ABS_W'(n1_reg) > (fend1_reg - ffy1_reg));
            n2_next   = n1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op2_reg  <= op1_reg;
            err2_reg <= err2_next;
            y2_reg   <= y1_reg;
            m2_reg   <= m1_reg;
            d2_reg   <= d1_reg;
            n2_reg   <= n2_next;
            a2_reg   <= ffy1_reg + gdn_pkg::ABS_W'(n1_reg) - gdn_pkg::ABS_W'(1);
        end
    end

    // stage 3: year estimate and weekday
    gdn_weekday u_weekday (
        .n  (n2_reg),
        .wd (wd_next)
    );

    assign est_prod = 44'(a2_reg) * 44'(gdn_pkg::YEAR_RECIP);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op3_reg  <= op2_reg;
            err3_reg <= err2_reg;
            y3_reg   <= y2_reg;
            m3_reg   <= m2_reg;
            d3_reg   <= d2_reg;
            n3_reg   <= n2_reg;
            a3_reg   <= a2_reg;
            wd3_reg  <= wd_next;
            est3_reg <= est_prod[gdn_pkg::YEAR_RECIP_SH +: gdn_pkg::YWIDE_W];
        end
    end

    // stage 4: settle the year among three candidates
    always_comb
    begin
        base = (est3_reg == '0) ? '0 : est3_reg - gdn_pkg::YWIDE_W'(1);
        fb0  = gdn_pkg::abs_days(base);
        fb1  = gdn_pkg::abs_days(base + gdn_pkg::YWIDE_W'(1));
        fb2  = gdn_pkg::abs_days(base + gdn_pkg::YWIDE_W'(2));
        priority if (fb2 <= a3_reg)
        begin
            yc_next = base + gdn_pkg::YWIDE_W'(2);
            f_next  = fb2;
        end
        else if (fb1 <= a3_reg)
        begin
            yc_next = base + gdn_pkg::YWIDE_W'(1);
            f_next  = fb1;
        end
        else
        begin
            yc_next = base;
            f_next  = fb0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op4_reg  <= op3_reg;
            err4_reg <= err3_reg;
            y4_reg   <= y3_reg;
            m4_reg   <= m3_reg;
            d4_reg   <= d3_reg;
            n4_reg   <= n3_reg;
            a4_reg   <= a3_reg;
            wd4_reg  <= wd3_reg;
            yc4_reg  <= yc_next;
            f4_reg   <= f_next;
        end
    end

    // stage 5: day of year and leap flag of the found year
    assign doy_wide = a4_reg - f4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op5_reg   <= op4_reg;
            err5_reg  <= err4_reg;
            y5_reg    <= y4_reg;
            m5_reg    <= m4_reg;
            d5_reg    <= d4_reg;
            n5_reg    <= n4_reg;
            wd5_reg   <= wd4_reg;
            yc5_reg   <= yc4_reg;
            doy5_reg  <= doy_wide[gdn_pkg::DOY_W-1:0];
            leap5_reg <= gdn_pkg::is_leap(yc4_reg);
        end
    end

    // stage 6: month search and result select
    always_comb
    begin
        msel = gdn_pkg::MONTH_JAN;
        for (int k = 2; k <= 12; k++)
        begin
            if (doy5_reg >= gdn_pkg::cum_days(gdn_pkg::MONTH_W'(k), leap5_reg))
            begin
                msel = gdn_pkg::MONTH_W'(k);
            end
        end
        dsel = doy5_reg - gdn_pkg::cum_days(msel, leap5_reg) + gdn_pkg::DOY_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            err6_reg <= err5_reg;
            if (err5_reg)
            begin
                on6_reg  <= '0;
                oy6_reg  <= '0;
                om6_reg  <= '0;
                od6_reg  <= '0;
                owd6_reg <= '0;
            end
            else if (op5_reg == gdn_pkg::OP_TO_DNUM)
            begin
                on6_reg  <= n5_reg;
                oy6_reg  <= y5_reg;
                om6_reg  <= m5_reg;
                od6_reg  <= d5_reg;
                owd6_reg <= wd5_reg;
            end
            else
            begin
                on6_reg  <= n5_reg;
                oy6_reg  <= yc5_reg[gdn_pkg::YEAR_W-1:0];
                om6_reg  <= msel;
                od6_reg  <= dsel[gdn_pkg::DAY_W-1:0];
                owd6_reg <= wd5_reg;
            end
        end
    end

    assign rsp.valid          = v6_reg;
    assign rsp.error          = err6_reg;
    assign rsp.out_day_number = on6_reg;
    assign rsp.out_year       = oy6_reg;
    assign rsp.out_month      = om6_reg;
    assign rsp.out_day        = od6_reg;
    assign rsp.weekday        = owd6_reg;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.error |-> rsp.out_day_number == '0 && rsp.weekday == '0)
        else $error("error result carries nonzero fields");

    a_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.error |-> rsp.weekday != '0 &&
        rsp.out_month >= gdn_pkg::MONTH_JAN && rsp.out_month <= gdn_pkg::MONTH_DEC &&
        rsp.out_day != '0)
        else $error("good result with bad weekday, month or day");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> v1_reg)
        else $error("accepted request lost at pipe entry");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v5_reg) && $stable(n5_reg))
        else $error("pipe moved during stall");
endmodule
